/* rtl/core/ihex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX parser package
// Shared types, result codes and character constants of the record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_START     = 3'd1;
  localparam logic [2:0] ERR_DIGIT     = 3'd2;
  localparam logic [2:0] ERR_TYPE      = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
  localparam logic [2:0] ERR_LENGTH    = 3'd5;
  localparam logic [2:0] ERR_CAPACITY  = 3'd6;
  localparam logic [2:0] ERR_TRUNCATED = 3'd7;

  localparam logic [7:0] REC_DATA       = 8'd0;
  localparam logic [7:0] REC_EOF        = 8'd1;
  localparam logic [7:0] REC_EXT_SEG    = 8'd2;
  localparam logic [7:0] REC_START_SEG  = 8'd3;
  localparam logic [7:0] REC_EXT_LIN    = 8'd4;
  localparam logic [7:0] REC_START_LIN  = 8'd5;

  localparam logic [7:0] LEN_SHORT_REC = 8'd2;
  localparam logic [7:0] LEN_LONG_REC  = 8'd4;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] NIBBLE_TEN   = 8'h0A;

  localparam logic [15:0] MAX_RECORDS_RESET = 16'hFFFF;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
    logic       is_blank;
    logic       is_colon;
  } char_info_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  byte_value;
    logic [31:0] byte_address;
    logic [2:0]  rec_type;
    logic [7:0]  rec_length;
    logic [15:0] rec_address;
    logic [15:0] upper_address;
    logic [2:0]  error_code;
    logic [15:0] records_stored;
    logic [31:0] total_data_bytes;
  } result_t;

  typedef struct packed {
    logic        halted;
    logic [15:0] record_counter;
  } status_t;

endpackage

/* rtl/core/ihex_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX parser input channel
// Valid/ready channel that carries one text character or an end-of-input word.
// ----------------------------------------------------------------------------
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink (input valid, input req_type, input char_code, output ready);
endinterface

/* rtl/core/ihex_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX parser result channel
// Valid/ready channel that carries one result word of the parser.
// ----------------------------------------------------------------------------
interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  byte_value;
  logic [31:0] byte_address;
  logic [2:0]  rec_type;
  logic [7:0]  rec_length;
  logic [15:0] rec_address;
  logic [15:0] upper_address;
  logic [2:0]  error_code;
  logic [15:0] records_stored;
  logic [31:0] total_data_bytes;

  modport source (
    output valid, output result_kind, output byte_value, output byte_address,
    output rec_type, output rec_length, output rec_address, output upper_address,
    output error_code, output records_stored, output total_data_bytes,
    input ready
  );
  modport sink (
    input valid, input result_kind, input byte_value, input byte_address,
    input rec_type, input rec_length, input rec_address, input upper_address,
    input error_code, input records_stored, input total_data_bytes,
    output ready
  );
endinterface

/* rtl/core/ihex_char_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX character decoder
// Classifies a character as hex digit, whitespace or colon and gives its nibble.
// ----------------------------------------------------------------------------
module ihex_char_decode (
  input  logic [7:0]          char_code,
  output ihex_pkg::char_info_t info
);
  import ihex_pkg::*;

  always_comb begin
    info = '0;
    info.is_colon = (char_code == CHAR_COLON);
    info.is_blank = (char_code == CHAR_SPACE) ||
                    ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    if ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)) begin
      info.is_hex = 1'b1;
      info.nibble = 4'(char_code - CHAR_ZERO);
    end else if ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F)) begin
      info.is_hex = 1'b1;
      info.nibble = 4'(char_code - CHAR_LOWER_A + NIBBLE_TEN);
    end else if ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F)) begin
      info.is_hex = 1'b1;
      info.nibble = 4'(char_code - CHAR_UPPER_A + NIBBLE_TEN);
    end
  end

endmodule

/* rtl/core/ihex_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX parse core
// Record state machine: one word per step, at most one result per step.
// ----------------------------------------------------------------------------
module ihex_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic              req_type,
  input  logic [7:0]        char_code,
  input  logic [15:0]       max_records,
  output logic              res_valid,
  output ihex_pkg::result_t res,
  output ihex_pkg::status_t status
);
  import ihex_pkg::*;

  typedef enum logic [2:0] {
    PH_COLON, PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_SUM, PH_ERROR, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  length_field, length_field_next;
  logic [15:0] address_field, address_field_next;
  logic [7:0]  type_field, type_field_next;
  logic [7:0]  data_index, data_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] first_two_bytes, first_two_bytes_next;
  logic [15:0] linear_base, linear_base_next;
  logic [15:0] record_counter, record_counter_next;
  logic [31:0] byte_total, byte_total_next;

  char_info_t  info;
  logic [7:0]  pair_byte;
  logic [7:0]  sum_with_byte;
  logic [7:0]  index_inc;
  logic [32:0] total_sum;
  logic        halted;
  logic        length_bad;

  ihex_char_decode u_decode (
    .char_code (char_code),
    .info      (info)
  );

  assign halted        = (phase == PH_ERROR) || (phase == PH_DONE);
  assign pair_byte     = {high_nibble, info.nibble};
  assign sum_with_byte = 8'(running_sum + pair_byte);
  assign index_inc     = 8'(data_index + 8'd1);
  assign total_sum     = {1'b0, byte_total} + 33'(length_field);

  always_comb begin
    case (type_field) inside
      REC_EXT_SEG, REC_EXT_LIN:    length_bad = (length_field != LEN_SHORT_REC);
      REC_START_SEG, REC_START_LIN: length_bad = (length_field != LEN_LONG_REC);
      REC_EOF:                     length_bad = (length_field != 8'd0);
      default:                     length_bad = 1'b0;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    digit_count_next     = digit_count;
    high_nibble_next     = high_nibble;
    length_field_next    = length_field;
    address_field_next   = address_field;
    type_field_next      = type_field;
    data_index_next      = data_index;
    running_sum_next     = running_sum;
    first_two_bytes_next = first_two_bytes;
    linear_base_next     = linear_base;
    record_counter_next  = record_counter;
    byte_total_next      = byte_total;
    res_valid            = 1'b0;
    res                  = '0;

    if (step_en && !halted) begin
      if (req_type) begin
        res_valid = 1'b1;
        if (phase == PH_COLON) begin
          phase_next      = PH_DONE;
          res.result_kind = KIND_END;
        end else begin
          phase_next      = PH_ERROR;
          res.result_kind = KIND_ERROR;
          res.error_code  = ERR_TRUNCATED;
        end
      end else if (phase == PH_COLON) begin
        if (info.is_colon) begin
          digit_count_next     = '0;
          high_nibble_next     = '0;
          length_field_next    = '0;
          address_field_next   = '0;
          type_field_next      = '0;
          data_index_next      = '0;
          running_sum_next     = '0;
          first_two_bytes_next = '0;
          phase_next           = PH_LEN;
        end else if (!info.is_blank) begin
          res_valid       = 1'b1;
          phase_next      = PH_ERROR;
          res.result_kind = KIND_ERROR;
          res.error_code  = ERR_START;
        end
      end else if (!info.is_hex) begin
        res_valid       = 1'b1;
        phase_next      = PH_ERROR;
        res.result_kind = KIND_ERROR;
        res.error_code  = ERR_DIGIT;
      end else if (!digit_count[0]) begin
        high_nibble_next = info.nibble;
        digit_count_next = 3'(digit_count + 3'd1);
      end else begin
        unique case (phase)
          PH_LEN: begin
            length_field_next = pair_byte;
            running_sum_next  = sum_with_byte;
            digit_count_next  = '0;
            phase_next        = PH_ADDR;
          end
          PH_ADDR: begin
            address_field_next = {address_field[7:0], pair_byte};
            running_sum_next   = sum_with_byte;
            if (digit_count == 3'd3) begin
              digit_count_next = '0;
              phase_next       = PH_TYPE;
            end else begin
              digit_count_next = 3'(digit_count + 3'd1);
            end
          end
          PH_TYPE: begin
            type_field_next  = pair_byte;
            running_sum_next = sum_with_byte;
            digit_count_next = '0;
            if (pair_byte > REC_START_LIN) begin
              res_valid       = 1'b1;
              phase_next      = PH_ERROR;
              res.result_kind = KIND_ERROR;
              res.error_code  = ERR_TYPE;
            end else begin
              phase_next = (length_field != 8'd0) ? PH_DATA : PH_SUM;
            end
          end
          PH_DATA: begin
            running_sum_next = sum_with_byte;
            if (data_index < 8'd2) begin
              first_two_bytes_next = {first_two_bytes[7:0], pair_byte};
            end
            data_index_next  = index_inc;
            digit_count_next = '0;
            if (index_inc >= length_field) begin
              phase_next = PH_SUM;
            end
            if (type_field == REC_DATA) begin
              res_valid        = 1'b1;
              res.result_kind  = KIND_DATA;
              res.byte_value   = pair_byte;
              res.byte_address = {linear_base, 16'h0000} + {16'h0000, address_field} +
                                 {24'h000000, data_index};
              res.rec_type     = type_field[2:0];
              res.rec_length   = length_field;
              res.rec_address  = address_field;
            end
          end
          default: begin
            digit_count_next = '0;
            res_valid        = 1'b1;
            if (sum_with_byte != 8'd0) begin
              phase_next      = PH_ERROR;
              res.result_kind = KIND_ERROR;
              res.error_code  = ERR_CHECKSUM;
            end else if (length_bad) begin
              phase_next      = PH_ERROR;
              res.result_kind = KIND_ERROR;
              res.error_code  = ERR_LENGTH;
            end else begin
              if (type_field == REC_EXT_LIN) begin
                linear_base_next = first_two_bytes;
              end
              if (type_field == REC_DATA) begin
                if (record_counter != 16'hFFFF) begin
                  record_counter_next = 16'(record_counter + 16'd1);
                end
                byte_total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
              end
              if ((max_records != 16'd0) && (record_counter_next >= max_records)) begin
                phase_next      = PH_ERROR;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_CAPACITY;
              end else begin
                phase_next      = PH_COLON;
                res.result_kind = KIND_RECORD;
                res.rec_type    = type_field[2:0];
                res.rec_length  = length_field;
                res.rec_address = address_field;
              end
            end
          end
        endcase
      end
    end

    res.upper_address    = linear_base_next;
    res.records_stored   = record_counter_next;
    res.total_data_bytes = byte_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COLON;
      digit_count     <= '0;
      high_nibble     <= '0;
      length_field    <= '0;
      address_field   <= '0;
      type_field      <= '0;
      data_index      <= '0;
      running_sum     <= '0;
      first_two_bytes <= '0;
      linear_base     <= '0;
      record_counter  <= '0;
      byte_total      <= '0;
    end else begin
      phase           <= phase_next;
      digit_count     <= digit_count_next;
      high_nibble     <= high_nibble_next;
      length_field    <= length_field_next;
      address_field   <= address_field_next;
      type_field      <= type_field_next;
      data_index      <= data_index_next;
      running_sum     <= running_sum_next;
      first_two_bytes <= first_two_bytes_next;
      linear_base     <= linear_base_next;
      record_counter  <= record_counter_next;
      byte_total      <= byte_total_next;
    end
  end

  assign status.halted         = halted;
  assign status.record_counter = record_counter;

endmodule

/* rtl/core/intel_hex_record_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Parses Intel HEX text one character word at a time into data byte and
// record status words.
// ----------------------------------------------------------------------------
// The item channel carries one character, or an end-of-input marker, per word.
// The result channel carries data bytes of data records with their 32-bit
// address, a status word per accepted record, one error word, or the end
// summary. wr_en/wr_data set the data record capacity; the user must write it
// only while the block is idle; the block itself does not enforce this. A word
// is registered on acceptance and parsed once the result register is free or
// being drained, and its result, if any, is registered at that parse step.
// The sustained rate is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result stays in the output register, the input
// register holds the next word and the item channel deasserts ready.
// After an error or the end summary the block takes words and gives no results
// until reset. Reset clears all parser state, sets the capacity to 65535 and
// empties both registers.
// ----------------------------------------------------------------------------
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  ihex_in_if.sink     item,
  ihex_out_if.source  result
);
  import ihex_pkg::*;

  logic        in_valid;
  logic        in_req_type;
  logic [7:0]  in_char_code;
  logic        out_valid;
  result_t     out_data;
  logic [15:0] max_records;
  logic        step;
  logic        core_valid;
  result_t     core_res;
  status_t     core_status;

  assign step       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      max_records <= MAX_RECORDS_RESET;
    end else begin
      if (wr_en) begin
        max_records <= wr_data;
      end
      if (item.ready) begin
        in_valid <= item.valid;
      end
      if (step) begin
        out_valid <= core_valid;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_req_type  <= item.req_type;
      in_char_code <= item.char_code;
    end
    if (step && core_valid) begin
      out_data <= core_res;
    end
  end

  ihex_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (step),
    .req_type    (in_req_type),
    .char_code   (in_char_code),
    .max_records (max_records),
    .res_valid   (core_valid),
    .res         (core_res),
    .status      (core_status)
  );

  assign result.valid            = out_valid;
  assign result.result_kind      = out_data.result_kind;
  assign result.byte_value       = out_data.byte_value;
  assign result.byte_address     = out_data.byte_address;
  assign result.rec_type         = out_data.rec_type;
  assign result.rec_length       = out_data.rec_length;
  assign result.rec_address      = out_data.rec_address;
  assign result.upper_address    = out_data.upper_address;
  assign result.error_code       = out_data.error_code;
  assign result.records_stored   = out_data.records_stored;
  assign result.total_data_bytes = out_data.total_data_bytes;

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.result_kind == KIND_ERROR)) |-> (out_data.error_code != ERR_NONE))
    else $error("error word without an error code");

  a_other_no_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.result_kind != KIND_ERROR)) |-> (out_data.error_code == ERR_NONE))
    else $error("non-error word carries an error code");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    core_status.halted |-> !core_valid)
    else $error("halted parser produced a result");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (core_status.record_counter >= $past(core_status.record_counter)))
    else $error("record count decreased");

endmodule

/* bench/ihex_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX parser stream checker
// Watches the character and result channels of the record parser, predicts
// every result word from the accepted character words and the capacity
// register, and compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module ihex_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  ihex_in_if          item,
  ihex_out_if         result,
  output int          fail_count,
  output int          pending
);
  import ihex_pkg::*;

  typedef enum logic [2:0] {
    SEEK_COLON, READ_LENGTH, READ_ADDRESS, READ_TYPE,
    READ_DATA, READ_CHECKSUM, HALT_ERROR, HALT_END
  } parse_phase_t;

  parse_phase_t phase;
  logic [2:0]   digit_cnt;
  logic [3:0]   hi_nib;
  logic [7:0]   rec_len;
  logic [15:0]  rec_addr;
  logic [7:0]   rec_kind;
  logic [7:0]   byte_idx;
  logic [7:0]   sum;
  logic [15:0]  lead_bytes;
  logic [15:0]  upper;
  logic [15:0]  rec_count;
  logic [31:0]  byte_sum;
  logic [15:0]  capacity;
  result_t      parsed_words[$];
  int           mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic void clear_record();
    digit_cnt = '0;
    hi_nib = '0;
    rec_len = '0;
    rec_addr = '0;
    rec_kind = '0;
    byte_idx = '0;
    sum = '0;
    lead_bytes = '0;
  endfunction

  function automatic result_t make_word(input logic [1:0] kind, input logic [7:0] value,
                                        input logic [31:0] addr, input bit with_rec,
                                        input logic [2:0] err);
    result_t w;
    w = '0;
    w.result_kind = kind;
    w.byte_value = value;
    w.byte_address = addr;
    if (with_rec) begin
      w.rec_type = rec_kind[2:0];
      w.rec_length = rec_len;
      w.rec_address = rec_addr;
    end
    w.upper_address = upper;
    w.error_code = err;
    w.records_stored = rec_count;
    w.total_data_bytes = byte_sum;
    return w;
  endfunction

  function automatic result_t halt_with(input logic [2:0] err);
    phase = HALT_ERROR;
    return make_word(KIND_ERROR, 8'h00, 32'h0, 1'b0, err);
  endfunction

  // Advances the parser by one character word; returns 1 when it yields a result word.
  function automatic bit parse_word(input logic at_end, input logic [7:0] ch,
                                    output result_t w);
    logic [3:0]  nib;
    logic [7:0]  b;
    logic [7:0]  check;
    logic [31:0] addr;
    w = '0;
    if (phase == HALT_ERROR || phase == HALT_END) return 1'b0;
    if (at_end) begin
      if (phase == SEEK_COLON) begin
        phase = HALT_END;
        w = make_word(KIND_END, 8'h00, 32'h0, 1'b0, ERR_NONE);
        return 1'b1;
      end
      w = halt_with(ERR_TRUNCATED);
      return 1'b1;
    end
    if (phase == SEEK_COLON) begin
      if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR)) return 1'b0;
      if (ch != CHAR_COLON) begin
        w = halt_with(ERR_START);
        return 1'b1;
      end
      clear_record();
      phase = READ_LENGTH;
      return 1'b0;
    end
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) nib = 4'(ch - CHAR_ZERO);
    else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) nib = 4'(ch - CHAR_LOWER_A + NIBBLE_TEN);
    else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) nib = 4'(ch - CHAR_UPPER_A + NIBBLE_TEN);
    else begin
      w = halt_with(ERR_DIGIT);
      return 1'b1;
    end
    if (!digit_cnt[0]) begin
      hi_nib = nib;
      digit_cnt = digit_cnt + 3'd1;
      return 1'b0;
    end
    b = {hi_nib, nib};
    digit_cnt = digit_cnt + 3'd1;
    case (phase)
      READ_LENGTH: begin
        rec_len = b;
        sum = sum + b;
        digit_cnt = '0;
        phase = READ_ADDRESS;
        return 1'b0;
      end
      READ_ADDRESS: begin
        rec_addr = {rec_addr[7:0], b};
        sum = sum + b;
        if (digit_cnt >= 3'd4) begin
          digit_cnt = '0;
          phase = READ_TYPE;
        end
        return 1'b0;
      end
      READ_TYPE: begin
        rec_kind = b;
        sum = sum + b;
        digit_cnt = '0;
        if (b > REC_START_LIN) begin
          w = halt_with(ERR_TYPE);
          return 1'b1;
        end
        phase = (rec_len != 8'd0) ? READ_DATA : READ_CHECKSUM;
        return 1'b0;
      end
      READ_DATA: begin
        addr = {upper, 16'h0000} + rec_addr + byte_idx;
        sum = sum + b;
        if (byte_idx < 8'd2) lead_bytes = {lead_bytes[7:0], b};
        byte_idx = byte_idx + 8'd1;
        digit_cnt = '0;
        if (byte_idx >= rec_len) phase = READ_CHECKSUM;
        if (rec_kind == REC_DATA) begin
          w = make_word(KIND_DATA, b, addr, 1'b1, ERR_NONE);
          return 1'b1;
        end
        return 1'b0;
      end
      default: ;
    endcase
    digit_cnt = '0;
    check = sum + b;
    if (check != 8'd0) begin
      w = halt_with(ERR_CHECKSUM);
      return 1'b1;
    end
    if (((rec_kind == REC_EXT_SEG || rec_kind == REC_EXT_LIN) && rec_len != LEN_SHORT_REC) ||
        ((rec_kind == REC_START_SEG || rec_kind == REC_START_LIN) && rec_len != LEN_LONG_REC) ||
        (rec_kind == REC_EOF && rec_len != 8'd0)) begin
      w = halt_with(ERR_LENGTH);
      return 1'b1;
    end
    if (rec_kind == REC_EXT_LIN) upper = lead_bytes;
    if (rec_kind == REC_DATA) begin
      if (rec_count != 16'hFFFF) rec_count = rec_count + 16'd1;
      if (byte_sum > 32'hFFFF_FFFF - rec_len) byte_sum = 32'hFFFF_FFFF;
      else byte_sum = byte_sum + rec_len;
    end
    phase = SEEK_COLON;
    if (capacity != 16'd0 && rec_count >= capacity) begin
      w = halt_with(ERR_CAPACITY);
      return 1'b1;
    end
    w = make_word(KIND_RECORD, 8'h00, 32'h0, 1'b1, ERR_NONE);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_total++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clear_record();
      phase = SEEK_COLON;
      upper = '0;
      rec_count = '0;
      byte_sum = '0;
      capacity = MAX_RECORDS_RESET;
      parsed_words.delete();
    end else begin
      if (wr_en) capacity = wr_data;
      if (item.valid && item.ready) begin
        if (parse_word(item.req_type, item.char_code, want)) parsed_words.push_back(want);
      end
      if (result.valid && result.ready) begin
        if (parsed_words.size() == 0) begin
          mismatch_total++;
          $display("%0t: result word expected none actual kind %0h", $time,
                   result.result_kind);
        end else begin
          want = parsed_words.pop_front();
          check_field("result_kind", want.result_kind, result.result_kind);
          check_field("byte_value", want.byte_value, result.byte_value);
          check_field("byte_address", want.byte_address, result.byte_address);
          check_field("rec_type", want.rec_type, result.rec_type);
          check_field("rec_length", want.rec_length, result.rec_length);
          check_field("rec_address", want.rec_address, result.rec_address);
          check_field("upper_address", want.upper_address, result.upper_address);
          check_field("error_code", want.error_code, result.error_code);
          check_field("records_stored", want.records_stored, result.records_stored);
          check_field("total_data_bytes", want.total_data_bytes, result.total_data_bytes);
        end
      end
    end
    pending <= parsed_words.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Feeds the parser directed and random Intel HEX text in three flow-control
// phases with different capacity settings, ends the stream with one randomly
// chosen terminating case, and reports the verdict of the stream checker.
// ----------------------------------------------------------------------------
module tb_top;
  import ihex_pkg::*;

  localparam int RUN_LIMIT_NS    = 2_000_000;
  localparam int WORDS_PER_PHASE = 300;

  typedef enum int {
    END_CLEAN, END_BAD_START, END_BAD_DIGIT, END_BAD_TYPE,
    END_BAD_SUM, END_BAD_LENGTH, END_CAPACITY, END_TRUNCATED
  } ending_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [15:0] wr_data;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fail_count;
  int          pending_count;
  int          words_sent = 0;
  int          data_records_sent = 0;
  logic [7:0]  body_q[$];
  logic [7:0]  line_q[$];

  ihex_in_if  item_ch ();
  ihex_out_if result_ch ();

  intel_hex_record_parser u_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data),
    .item(item_ch), .result(result_ch)
  );

  ihex_stream_checker u_check (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data),
    .item(item_ch), .result(result_ch),
    .fail_count(fail_count), .pending(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(5) == 0) return CHAR_SPACE;
    return 8'($urandom_range(CHAR_CR, CHAR_TAB));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_ZERO + n;
    return ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + n - NIBBLE_TEN;
  endfunction

  function automatic logic [7:0] start_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CHAR_COLON || is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] digit_junk();
    logic [7:0] c;
    case ($urandom_range(2))
      0: c = blank_char();
      1: case ($urandom_range(5))
        0: c = CHAR_ZERO - 8'd1;
        1: c = CHAR_NINE + 8'd1;
        2: c = CHAR_UPPER_A - 8'd1;
        3: c = CHAR_UPPER_F + 8'd1;
        4: c = CHAR_LOWER_A - 8'd1;
        default: c = CHAR_LOWER_F + 8'd1;
      endcase
      default: do c = 8'($urandom_range(255)); while (is_hex(c));
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_address();
    if ($urandom_range(4) == 0) return 16'hFFF0 + 16'($urandom_range(15));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic void fill_body(input int size);
    body_q.delete();
    repeat (size) body_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_hex(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endfunction

  // Turns body_q into one record line; a nonzero skew spoils the checksum.
  function automatic void build_line(input logic [7:0] kind, input logic [15:0] addr,
                                     input logic [7:0] skew);
    logic [7:0] len;
    logic [7:0] total;
    len = 8'(body_q.size());
    total = len + addr[15:8] + addr[7:0] + kind;
    line_q.delete();
    line_q.push_back(CHAR_COLON);
    add_hex(len);
    add_hex(addr[15:8]);
    add_hex(addr[7:0]);
    add_hex(kind);
    foreach (body_q[i]) begin
      add_hex(body_q[i]);
      total = total + body_q[i];
    end
    add_hex(8'h00 - total + skew);
  endfunction

  function automatic void pick_record(output logic [7:0] kind);
    int roll;
    int size;
    roll = $urandom_range(99);
    if (roll < 70) kind = REC_DATA;
    else kind = REC_EOF + 8'((roll - 70) / 6);
    roll = $urandom_range(99);
    case (kind) inside
      REC_DATA: size = roll < 90 ? $urandom_range(16) :
                       roll < 98 ? $urandom_range(64, 17) : $urandom_range(255, 250);
      REC_EOF: size = 0;
      REC_EXT_SEG, REC_EXT_LIN: size = LEN_SHORT_REC;
      default: size = LEN_LONG_REC;
    endcase
    fill_body(size);
    if (kind == REC_EXT_LIN && roll < 25) begin
      body_q[0] = roll[0] ? 8'hFF : 8'h00;
      body_q[1] = body_q[0];
    end
  endfunction

  task automatic send_word(input logic at_end, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.req_type <= at_end;
    item_ch.char_code <= ch;
    do @(posedge clk); while (!item_ch.ready);
    words_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_word(1'b0, line_q[i]);
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(2) == 0 ? $urandom_range(3, 1) : 0) send_word(1'b0, blank_char());
  endtask

  task automatic send_good_record();
    logic [7:0] kind;
    pick_record(kind);
    build_line(kind, pick_address(), 8'h00);
    send_blanks();
    send_line();
    if (kind == REC_DATA) data_records_sent++;
  endtask

  task automatic send_records(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) send_good_record();
  endtask

  task automatic drain(input int tail);
    item_ch.valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic settle_and_write(input logic [15:0] cap);
    drain(6);
    wr_en <= 1'b1;
    wr_data <= cap;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic send_ending();
    ending_t    how;
    logic [7:0] kind;
    int         cut;
    int         size;
    how = ending_t'($urandom_range(7));
    case (how)
      END_CLEAN: begin
        send_blanks();
        send_word(1'b1, 8'($urandom_range(255)));
      end
      END_BAD_START: begin
        send_blanks();
        send_word(1'b0, start_junk());
      end
      END_BAD_DIGIT: begin
        pick_record(kind);
        build_line(kind, pick_address(), 8'h00);
        cut = $urandom_range(line_q.size() - 1, 1);
        line_q[cut] = digit_junk();
        send_line();
      end
      END_BAD_TYPE: begin
        fill_body($urandom_range(4));
        build_line(8'($urandom_range(255, 6)), pick_address(), 8'h00);
        send_line();
      end
      END_BAD_SUM: begin
        pick_record(kind);
        build_line(kind, pick_address(), 8'($urandom_range(255, 1)));
        send_line();
      end
      END_BAD_LENGTH: begin
        kind = 8'($urandom_range(REC_START_LIN, REC_EOF));
        do size = $urandom_range(8);
        while ((kind == REC_EOF && size == 0) ||
               ((kind == REC_EXT_SEG || kind == REC_EXT_LIN) && size == LEN_SHORT_REC) ||
               ((kind == REC_START_SEG || kind == REC_START_LIN) && size == LEN_LONG_REC));
        fill_body(size);
        build_line(kind, pick_address(), 8'h00);
        send_line();
      end
      END_CAPACITY: begin
        settle_and_write($urandom_range(1) ? 16'd1 :
                         16'(data_records_sent + $urandom_range(3, 1)));
        repeat (4) begin
          fill_body($urandom_range(8, 1));
          build_line(REC_DATA, pick_address(), 8'h00);
          send_blanks();
          send_line();
        end
      end
      default: begin
        pick_record(kind);
        build_line(kind, pick_address(), 8'h00);
        cut = $urandom_range(line_q.size() - 1, 1);
        while (line_q.size() > cut) void'(line_q.pop_back());
        send_line();
        send_word(1'b1, 8'($urandom_range(255)));
      end
    endcase
    // The parser is halted now; these words must be swallowed silently.
    repeat (20) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.req_type <= 1'b0;
    item_ch.char_code <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    settle_and_write(MAX_RECORDS_RESET);
    send_idle_pct = 34;
    recv_idle_pct = 83;
    // Upper address of all ones, then a data record whose second byte wraps to zero.
    body_q.delete();
    body_q.push_back(8'hFF);
    body_q.push_back(8'hFF);
    build_line(REC_EXT_LIN, 16'h0000, 8'h00);
    send_line();
    body_q[1] = 8'h00;
    build_line(REC_DATA, 16'hFFFF, 8'h00);
    send_line();
    data_records_sent++;
    send_records(WORDS_PER_PHASE);

    settle_and_write(16'd0);
    send_idle_pct = 83;
    recv_idle_pct = 34;
    send_records(WORDS_PER_PHASE);

    settle_and_write(16'($urandom_range(16'hFFFE, 1000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_records(WORDS_PER_PHASE);

    send_ending();
    drain(8);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ihex_pkg.sv
rtl/core/ihex_in_if.sv
rtl/core/ihex_out_if.sv
rtl/core/ihex_char_decode.sv
rtl/core/ihex_parse_core.sv
rtl/core/intel_hex_record_parser.sv
bench/ihex_stream_checker.sv
bench/tb_top.sv
